// File: hdl/gfg_pkg.sv
// shared types and constants of the grid field gradient unit
package gfg_pkg;

  localparam int IDX_W     = 10;
  localparam int SAMPLE_W  = 24;
  localparam int DIFF_W    = 26;
  localparam int INV_W     = 24;
  localparam int FIELD_W   = 32;
  localparam int PROD_W    = DIFF_W + 1 + INV_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;

  localparam logic [1:0] BC_PERIODIC  = 2'd0;
  localparam logic [1:0] BC_DIRICHLET = 2'd1;
  localparam logic [1:0] BC_MIXED     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BC_LOW_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BC_HIGH_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BC_LOW_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BC_HIGH_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_X = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_Y = 3'd6;

  localparam logic [INV_W-1:0] INV_STEP_RESET = 24'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DRAIN,
    ST_DIFF,
    ST_MUL_X,
    ST_MUL_Y,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic             sh17;
    logic             zero;
  } axis_plan_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff;
    logic [INV_W-1:0]         inv;
    logic                     sh17;
  } scl_req_t;

endpackage

// File: hdl/gfg_grid_mem.sv
// single-port potential grid memory with registered read
module gfg_grid_mem
  import gfg_pkg::*;
#(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              addr,
  input  logic signed [SAMPLE_W-1:0] wdata,
  output logic signed [SAMPLE_W-1:0] rdata
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hdl/gfg_axis_plan.sv
// momentum mode sample pair and edge rule selection along one axis
module gfg_axis_plan
  import gfg_pkg::*;
#(
  parameter int N = 64
) (
  input  logic [IDX_W-1:0] pos,
  input  logic [1:0]       bc_lo,
  input  logic [1:0]       bc_hi,
  output axis_plan_t       plan
);

  localparam logic [IDX_W-1:0] END_IDX = IDX_W'(N - 1);
  localparam logic [IDX_W-1:0] PRE_END = IDX_W'(N - 2);
  localparam logic [IDX_W-1:0] ONE     = IDX_W'(1);
  localparam logic [IDX_W-1:0] ZERO    = IDX_W'(0);

  always_comb begin
    plan.idx_a = pos + ONE;
    plan.idx_b = pos - ONE;
    plan.sh17  = 1'b1;
    plan.zero  = 1'b0;
    priority if (pos == ZERO) begin
      plan.idx_a = ONE;
      priority if (bc_lo == BC_PERIODIC) begin
        plan.idx_b = PRE_END;
      end else if (bc_lo == BC_DIRICHLET) begin
        plan.idx_b = ZERO;
        plan.sh17  = 1'b0;
      end else begin
        plan.idx_b = ZERO;
        plan.zero  = 1'b1;
      end
    end else if (pos == END_IDX) begin
      plan.idx_b = PRE_END;
      priority if (bc_hi == BC_DIRICHLET) begin
        plan.idx_a = END_IDX;
        plan.sh17  = 1'b0;
      end else if (bc_hi == BC_MIXED) begin
        plan.idx_a = END_IDX;
        plan.zero  = 1'b1;
      end else begin
        // periodic high edge takes the low edge value
        plan.idx_a = ONE;
        plan.zero  = (bc_lo != BC_PERIODIC);
      end
    end else begin
      plan.zero = 1'b0;
    end
  end

endmodule

// File: hdl/gfg_scaler.sv
// shared multiply, round and saturate unit, two stages
module gfg_scaler
  import gfg_pkg::*;
(
  input  logic                      clk,
  input  scl_req_t                  req,
  output logic signed [FIELD_W-1:0] res
);

  localparam logic signed [PROD_W-1:0] MAX_V = {{(PROD_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [PROD_W-1:0] MIN_V = {{(PROD_W-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [PROD_W-1:0] RND17 = PROD_W'(65536);
  localparam logic signed [PROD_W-1:0] RND16 = PROD_W'(32768);

  logic signed [DIFF_W:0]   neg;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic                     sh17_r;
  logic signed [PROD_W-1:0] rnd_sum;
  logic signed [PROD_W-1:0] quot;
  logic signed [FIELD_W-1:0] res_nxt;

  assign neg      = -$signed({req.diff[DIFF_W-1], req.diff});
  assign prod_nxt = PROD_W'(neg) * PROD_W'($signed({1'b0, req.inv}));

  always_comb begin
    rnd_sum = prod_r + (sh17_r ? RND17 : RND16);
    quot    = sh17_r ? (rnd_sum >>> 17) : (rnd_sum >>> 16);
    priority if (quot > MAX_V) begin
      res_nxt = MAX_V[FIELD_W-1:0];
    end else if (quot < MIN_V) begin
      res_nxt = MIN_V[FIELD_W-1:0];
    end else begin
      res_nxt = quot[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sh17_r <= req.sh17;
    res    <= res_nxt;
  end

endmodule

// File: hdl/grid_field_gradient_unit.sv
// grid field gradient unit: potential grid store and negative gradient sequencer
// a write word is stored on acceptance; busy stays low and no result follows
// a read word raises busy and steps through fetch, drain, diff, mul_x, mul_y,
// wait and done; its result strobes back in idle, where the next word is
// taken in that same cycle; four fetches through the single memory port and
// one multiplier serving both axes pace each read; the receiver cannot stall
// synchronous active-low reset restores config and sequencer, not the grid
module grid_field_gradient_unit
  import gfg_pkg::*;
#(
  parameter int GRID_X = 64,
  parameter int GRID_Y = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_req_type,
  input  logic [5:0]                 in_col,
  input  logic [5:0]                 in_row,
  input  logic signed [SAMPLE_W-1:0] in_potential,
  output logic                       out_valid,
  output logic signed [FIELD_W-1:0]  out_field_x,
  output logic signed [FIELD_W-1:0]  out_field_y,
  output logic                       out_outside,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int DEPTH = GRID_X * GRID_Y;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [IDX_W:0] GX    = (IDX_W+1)'(GRID_X);
  localparam logic [IDX_W:0] GY    = (IDX_W+1)'(GRID_Y);
  localparam logic [IDX_W:0] GX_M1 = (IDX_W+1)'(GRID_X - 1);
  localparam logic [IDX_W:0] GY_M1 = (IDX_W+1)'(GRID_Y - 1);
  localparam logic [AW-1:0]  ROW_STRIDE = AW'(GRID_X);
  localparam logic [IDX_W-1:0] ONE = IDX_W'(1);

  // configuration
  logic             field_mode_r;
  logic [1:0]       bc_low_x_r, bc_high_x_r, bc_low_y_r, bc_high_y_r;
  logic [INV_W-1:0] inv_step_x_r, inv_step_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_mode_r <= 1'b0;
      bc_low_x_r   <= BC_PERIODIC;
      bc_high_x_r  <= BC_PERIODIC;
      bc_low_y_r   <= BC_PERIODIC;
      bc_high_y_r  <= BC_PERIODIC;
      inv_step_x_r <= INV_STEP_RESET;
      inv_step_y_r <= INV_STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIELD_MODE: field_mode_r <= cfg_data[0];
        REG_BC_LOW_X:   bc_low_x_r   <= cfg_data[1:0];
        REG_BC_HIGH_X:  bc_high_x_r  <= cfg_data[1:0];
        REG_BC_LOW_Y:   bc_low_y_r   <= cfg_data[1:0];
        REG_BC_HIGH_Y:  bc_high_y_r  <= cfg_data[1:0];
        REG_INV_STEP_X: inv_step_x_r <= cfg_data[INV_W-1:0];
        REG_INV_STEP_Y: inv_step_y_r <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_t       state_r, state_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         accept;
  logic         accept_rd;
  logic         accept_wr;
  logic [5:0]   col_r, row_r;
  logic         outside_r;
  logic         in_outside;
  logic         cap_vld_r;
  logic [1:0]   cap_idx_r;
  logic signed [SAMPLE_W-1:0] q_r [4];
  logic signed [DIFF_W-1:0]   dx_r, dy_r;
  logic signed [DIFF_W-1:0]   dx_nxt, dy_nxt;
  logic signed [DIFF_W-1:0]   q0, q1, q2, q3;
  logic         out_valid_r;
  logic signed [FIELD_W-1:0] out_field_x_r, out_field_y_r;
  logic         out_outside_r;

  // memory port
  logic                       mem_we;
  logic [AW-1:0]              mem_addr;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;
  logic signed [SAMPLE_W-1:0] mem_rdata;

  // fetch planning
  logic [IDX_W-1:0] cpos, rpos;
  logic [IDX_W-1:0] fx, fy;
  axis_plan_t       px, py;
  logic             zero_x, zero_y;
  logic             sh17_x, sh17_y;
  scl_req_t         scl_req;
  logic signed [FIELD_W-1:0] scl_res;

  assign accept    = start && !busy;
  assign accept_rd = accept && in_req_type;
  assign accept_wr = accept && !in_req_type
                     && ({{(IDX_W-5){1'b0}}, in_col} < GX)
                     && ({{(IDX_W-5){1'b0}}, in_row} < GY);

  always_comb begin
    if (field_mode_r) begin
      in_outside = ({{(IDX_W-5){1'b0}}, in_col} >= GX_M1)
                   || ({{(IDX_W-5){1'b0}}, in_row} >= GY_M1);
    end else begin
      in_outside = ({{(IDX_W-5){1'b0}}, in_col} >= GX)
                   || ({{(IDX_W-5){1'b0}}, in_row} >= GY);
    end
  end

  assign cpos = {{(IDX_W-6){1'b0}}, col_r};
  assign rpos = {{(IDX_W-6){1'b0}}, row_r};

  gfg_axis_plan #(.N(GRID_X)) u_plan_x (
    .pos   (cpos),
    .bc_lo (bc_low_x_r),
    .bc_hi (bc_high_x_r),
    .plan  (px)
  );

  gfg_axis_plan #(.N(GRID_Y)) u_plan_y (
    .pos   (rpos),
    .bc_lo (bc_low_y_r),
    .bc_hi (bc_high_y_r),
    .plan  (py)
  );

  always_comb begin
    fx = cpos;
    fy = rpos;
    if (field_mode_r) begin
      unique case (cnt_r)
        2'd0: begin fx = cpos + ONE; fy = rpos;       end
        2'd1: begin fx = cpos;       fy = rpos;       end
        2'd2: begin fx = cpos;       fy = rpos + ONE; end
        2'd3: begin fx = cpos + ONE; fy = rpos + ONE; end
        default: ;
      endcase
    end else begin
      unique case (cnt_r)
        2'd0: begin fx = px.idx_a; fy = rpos;     end
        2'd1: begin fx = px.idx_b; fy = rpos;     end
        2'd2: begin fx = cpos;     fy = py.idx_a; end
        2'd3: begin fx = cpos;     fy = py.idx_b; end
        default: ;
      endcase
    end
  end

  assign wr_addr  = AW'(AW'(in_row) * ROW_STRIDE + AW'(in_col));
  assign rd_addr  = AW'(AW'(fy) * ROW_STRIDE + AW'(fx));
  assign mem_addr = (state_r == ST_IDLE) ? wr_addr : rd_addr;
  assign mem_we   = accept_wr;

  gfg_grid_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_potential),
    .rdata (mem_rdata)
  );

  // difference forming
  assign zero_x = outside_r || (!field_mode_r && px.zero);
  assign zero_y = outside_r || (!field_mode_r && py.zero);
  assign sh17_x = field_mode_r || px.sh17;
  assign sh17_y = field_mode_r || py.sh17;

  assign q0 = DIFF_W'(q_r[0]);
  assign q1 = DIFF_W'(q_r[1]);
  assign q2 = DIFF_W'(q_r[2]);
  assign q3 = DIFF_W'(q_r[3]);

  always_comb begin
    if (field_mode_r) begin
      dx_nxt = q0 + q3 - q1 - q2;
      dy_nxt = q2 + q3 - q1 - q0;
    end else begin
      dx_nxt = q0 - q1;
      dy_nxt = q2 - q3;
    end
    if (zero_x) begin
      dx_nxt = '0;
    end
    if (zero_y) begin
      dy_nxt = '0;
    end
  end

  always_comb begin
    if (state_r == ST_MUL_X) begin
      scl_req.diff = dx_r;
      scl_req.inv  = inv_step_x_r;
      scl_req.sh17 = sh17_x;
    end else begin
      scl_req.diff = dy_r;
      scl_req.inv  = inv_step_y_r;
      scl_req.sh17 = sh17_y;
    end
  end

  gfg_scaler u_scaler (
    .clk (clk),
    .req (scl_req),
    .res (scl_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (accept_rd) begin
          state_nxt = ST_FETCH;
          cnt_nxt   = 2'd0;
        end
      end
      ST_FETCH: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_DIFF;
      ST_DIFF:  state_nxt = ST_MUL_X;
      ST_MUL_X: state_nxt = ST_MUL_Y;
      ST_MUL_Y: state_nxt = ST_WAIT;
      ST_WAIT:  state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= 2'd0;
      cap_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cap_vld_r   <= (state_r == ST_FETCH);
      out_valid_r <= (state_r == ST_DONE);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cap_idx_r <= cnt_r;
    if (accept_rd) begin
      col_r     <= in_col;
      row_r     <= in_row;
      outside_r <= in_outside;
    end
    if (cap_vld_r) begin
      q_r[cap_idx_r] <= mem_rdata;
    end
    if (state_r == ST_DIFF) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
    if (state_r == ST_WAIT) begin
      out_field_x_r <= scl_res;
    end
    if (state_r == ST_DONE) begin
      out_field_y_r <= scl_res;
      out_outside_r <= outside_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_field_x = out_field_x_r;
  assign out_field_y = out_field_y_r;
  assign out_outside = out_outside_r;

endmodule
